// ----- design/rc4_stream_cipher_macros.svh -----
// assertion macros for the rc4 engine checker
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RC4_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RC4_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rc4_pkg.sv -----
// shared types and constants of the rc4 engine
package rc4_pkg;

    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = 8;
    localparam int KEY_DEPTH     = 256;
    localparam int KEY_AW        = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KLEN_W        = 9;
    localparam logic [KLEN_W-1:0] KEY_LEN_RESET = 9'd16;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SCHED = 2'd1;
    localparam logic [1:0] CMD_CRYPT = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] key_index;
        logic [7:0] data_byte;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       message_end;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CR_A,
        ST_CR_B,
        ST_CR_KS,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J
    } state_t;

endpackage

// ----- design/rc4_stream_cipher.sv -----
// rc4 engine: key store, permutation memory, key schedule and crypt sequencer
//
// command channel: a transaction is taken at a rising edge with start high and busy low.
// request.command selects load key byte, run key schedule or crypt data byte; the
// unused fourth code is taken and dropped.
// load: written straight into the key store.
// schedule: 256 swaps, each in the steps read s[n], read s[j], write s[n] and write
// s[j], on the single write port of the permutation memory.
// crypt: each byte takes the steps read s[i], read s[j] and write s[i], keystream
// read and write s[j]; the next transaction is taken in the keystream step. the
// result is on result for one cycle with result_valid, registered from that step.
// the receiver cannot stall: a result is shown once and dropped.
// configuration: cfg_ready is always high; cfg_data sets the key length used by
// the schedule. write it only while the engine is idle.
// reset: indices cleared, the permutation reads as identity (per-entry valid bits),
// key length 16, key store contents undefined until loaded.
module rc4_stream_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  rc4_pkg::req_t                   request,
    output logic                            result_valid,
    output rc4_pkg::res_t                   result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rc4_pkg::KLEN_W-1:0]      cfg_data
);

    rc4_pkg::state_t                  state_reg, state_next;
    logic [7:0]                       i_reg, i_next;
    logic [7:0]                       j_reg, j_next;
    logic [7:0]                       a_reg, a_next;
    logic [7:0]                       b_reg, b_next;
    logic [7:0]                       data_reg, data_next;
    logic                             last_reg, last_next;
    logic                             fwd_hit_reg, fwd_hit_next;
    logic [7:0]                       fwd_val_reg, fwd_val_next;
    logic [rc4_pkg::PERM_AW-1:0]      n_reg, n_next;
    logic [rc4_pkg::KEY_AW-1:0]       kpos_reg, kpos_next;
    logic [7:0]                       jv_reg, jv_next;
    logic [7:0]                       held_reg, held_next;
    logic [rc4_pkg::KLEN_W-1:0]       key_len_reg;
    logic [rc4_pkg::KLEN_W-1:0]       key_len_eff;
    logic [rc4_pkg::KLEN_W-1:0]       kpos_inc;
    rc4_pkg::res_t                    result_reg, result_next;
    logic                             result_valid_reg, result_valid_next;

    logic [7:0]                       perm_mem [rc4_pkg::PERM_DEPTH];
    logic [rc4_pkg::PERM_DEPTH-1:0]   perm_vld_reg;
    logic [7:0]                       rd_data_reg;
    logic                             rd_vld_reg;
    logic [rc4_pkg::PERM_AW-1:0]      rd_addr_reg;
    logic [7:0]                       perm_q;
    logic                             mem_we;
    logic [rc4_pkg::PERM_AW-1:0]      mem_waddr;
    logic [7:0]                       mem_wdata;
    logic [rc4_pkg::PERM_AW-1:0]      mem_raddr;
    logic                             clr_vld;

    logic [7:0]                       key_mem [rc4_pkg::KEY_DEPTH];
    logic [7:0]                       key_q_reg;
    logic                             key_we;

    logic                             accept;
    logic [7:0]                       a_sel;
    logic [7:0]                       ks;

    assign busy         = (state_reg != rc4_pkg::ST_IDLE) && (state_reg != rc4_pkg::ST_CR_KS);
    assign accept       = start && !busy;
    assign cfg_ready    = 1'b1;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // entries not written since the last identity fill read as their own address
    assign perm_q = rd_vld_reg ? rd_data_reg : rd_addr_reg;

    always_comb
    begin
        if (key_len_reg == '0)
            key_len_eff = rc4_pkg::KLEN_W'(1);
        else if (key_len_reg > rc4_pkg::KLEN_W'(rc4_pkg::KEY_DEPTH))
            key_len_eff = rc4_pkg::KLEN_W'(rc4_pkg::KEY_DEPTH);
        else
            key_len_eff = key_len_reg;
    end

    assign kpos_inc = rc4_pkg::KLEN_W'(kpos_reg) + rc4_pkg::KLEN_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        data_next         = data_reg;
        last_next         = last_reg;
        fwd_hit_next      = fwd_hit_reg;
        fwd_val_next      = fwd_val_reg;
        n_next            = n_reg;
        kpos_next         = kpos_reg;
        jv_next           = jv_reg;
        held_next         = held_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = i_reg;
        mem_wdata         = a_reg;
        mem_raddr         = i_reg;
        clr_vld           = 1'b0;
        key_we            = 1'b0;
        a_sel             = fwd_hit_reg ? fwd_val_reg : perm_q;
        ks                = perm_q;

        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
            end
            rc4_pkg::ST_CR_A:
            begin
                a_next     = a_sel;
                j_next     = j_reg + a_sel;
                mem_raddr  = j_reg + a_sel;
                state_next = rc4_pkg::ST_CR_B;
            end
            rc4_pkg::ST_CR_B:
            begin
                b_next     = perm_q;
                mem_we     = 1'b1;
                mem_waddr  = i_reg;
                mem_wdata  = perm_q;
                mem_raddr  = a_reg + perm_q;
                state_next = rc4_pkg::ST_CR_KS;
            end
            rc4_pkg::ST_CR_KS:
            begin
                // both swap writes land on the keystream entry ahead of the memory
                if (rd_addr_reg == j_reg)
                    ks = a_reg;
                else if (rd_addr_reg == i_reg)
                    ks = b_reg;
                else
                    ks = perm_q;
                mem_we                  = 1'b1;
                mem_waddr               = j_reg;
                mem_wdata               = a_reg;
                result_next.result_byte = data_reg ^ ks;
                result_next.message_end = last_reg;
                result_valid_next       = 1'b1;
                state_next              = rc4_pkg::ST_IDLE;
            end
            rc4_pkg::ST_KS_RD_N:
            begin
                mem_raddr  = n_reg;
                state_next = rc4_pkg::ST_KS_RD_J;
            end
            rc4_pkg::ST_KS_RD_J:
            begin
                held_next  = perm_q;
                jv_next    = jv_reg + key_q_reg + perm_q;
                mem_raddr  = jv_reg + key_q_reg + perm_q;
                state_next = rc4_pkg::ST_KS_WR_N;
            end
            rc4_pkg::ST_KS_WR_N:
            begin
                mem_we     = 1'b1;
                mem_waddr  = n_reg;
                mem_wdata  = perm_q;
                state_next = rc4_pkg::ST_KS_WR_J;
            end
            rc4_pkg::ST_KS_WR_J:
            begin
                mem_we    = 1'b1;
                mem_waddr = jv_reg;
                mem_wdata = held_reg;
                n_next    = n_reg + rc4_pkg::PERM_AW'(1);
                if (kpos_inc >= key_len_eff)
                    kpos_next = '0;
                else
                    kpos_next = kpos_inc[rc4_pkg::KEY_AW-1:0];
                if (n_reg == rc4_pkg::PERM_AW'(rc4_pkg::PERM_DEPTH - 1))
                    state_next = rc4_pkg::ST_IDLE;
                else
                    state_next = rc4_pkg::ST_KS_RD_N;
            end
            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase

        if (accept)
        begin
            case (request.command)
                rc4_pkg::CMD_LOAD:
                begin
                    key_we = ({1'b0, request.key_index} <
                              rc4_pkg::KLEN_W'(rc4_pkg::KEY_DEPTH));
                end
                rc4_pkg::CMD_SCHED:
                begin
                    clr_vld    = 1'b1;
                    i_next     = '0;
                    j_next     = '0;
                    n_next     = '0;
                    kpos_next  = '0;
                    jv_next    = '0;
                    state_next = rc4_pkg::ST_KS_RD_N;
                end
                rc4_pkg::CMD_CRYPT:
                begin
                    i_next       = i_reg + 8'd1;
                    mem_raddr    = i_reg + 8'd1;
                    // s[i] may be the entry written back in this same cycle
                    fwd_hit_next = (state_reg == rc4_pkg::ST_CR_KS) &&
                                   ((i_reg + 8'd1) == j_reg);
                    fwd_val_next = a_reg;
                    data_next    = request.data_byte;
                    last_next    = request.last_byte;
                    state_next   = rc4_pkg::ST_CR_A;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rc4_pkg::ST_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            n_reg            <= '0;
            kpos_reg         <= '0;
            jv_reg           <= '0;
            fwd_hit_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            key_len_reg      <= rc4_pkg::KEY_LEN_RESET;
            perm_vld_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            n_reg            <= n_next;
            kpos_reg         <= kpos_next;
            jv_reg           <= jv_next;
            fwd_hit_reg      <= fwd_hit_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
                key_len_reg <= cfg_data;
            if (clr_vld)
                perm_vld_reg <= '0;
            else if (mem_we)
                perm_vld_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        data_reg    <= data_next;
        last_reg    <= last_next;
        fwd_val_reg <= fwd_val_next;
        held_reg    <= held_next;
        result_reg  <= result_next;
    end

    // permutation memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            perm_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= perm_mem[mem_raddr];
        rd_vld_reg  <= perm_vld_reg[mem_raddr];
        rd_addr_reg <= mem_raddr;
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[request.key_index[rc4_pkg::KEY_AW-1:0]] <= request.data_byte;
        key_q_reg <= key_mem[kpos_reg];
    end

endmodule

// ----- design/rc4_chk.sv -----
// port-level checker for the rc4 engine, bound to the top level
`include "rc4_stream_cipher_macros.svh"

module rc4_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input rc4_pkg::req_t               request,
    input logic                        result_valid
);

    logic crypt_take;
    logic sched_take;

    assign crypt_take = start && !busy && (request.command == rc4_pkg::CMD_CRYPT);
    assign sched_take = start && !busy && (request.command == rc4_pkg::CMD_SCHED);

    `RC4_ASSERT_IMP(a_crypt_gives_result, crypt_take, ##4 result_valid, "crypt without result")
    `RC4_ASSERT_IMP(a_result_has_crypt, result_valid, $past(crypt_take, 4), "result without crypt")
    `RC4_ASSERT_NXT(a_result_single, result_valid, !result_valid, "results back to back")
    `RC4_ASSERT_NXT(a_sched_busy, sched_take, busy, "schedule did not hold busy")

endmodule

bind rc4_stream_cipher rc4_chk u_rc4_chk (.*);

// ----- bench/rc4_stream_cipher_checker.sv -----
`timescale 1ns / 1ps
// rc4 engine checker: tracks key store and permutation, predicts and compares crypt results
module rc4_stream_cipher_checker
    import rc4_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  req_t                request,
    input  logic                result_valid,
    input  res_t                result,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [KLEN_W-1:0]   cfg_data,
    output int                  failures,
    output int                  pending
);

    logic [7:0]         sbox [PERM_DEPTH];
    logic [7:0]         key_bytes [KEY_DEPTH];
    logic [7:0]         pos_i;
    logic [7:0]         pos_j;
    logic [KLEN_W-1:0]  key_len;
    res_t               cipher_bytes [$];

    task automatic report_mismatch(input string msg);
        if (failures < 100)
        begin
            $display("%0t ns: %s", $time, msg);
        end
        failures++;
    endtask

    function automatic int key_span(input logic [KLEN_W-1:0] len);
        if (len == '0)
        begin
            return 1;
        end
        if (int'(len) > KEY_DEPTH)
        begin
            return KEY_DEPTH;
        end
        return int'(len);
    endfunction

    task automatic run_key_schedule();
        int         span;
        int         kpos;
        logic [7:0] jv;
        logic [7:0] held;
        span = key_span(key_len);
        kpos = 0;
        jv   = 8'h00;
        pos_i = 8'h00;
        pos_j = 8'h00;
        for (int n = 0; n < PERM_DEPTH; n++)
        begin
            sbox[n] = 8'(n);
        end
        for (int n = 0; n < PERM_DEPTH; n++)
        begin
            held     = sbox[n];
            jv       = jv + key_bytes[kpos] + held;
            sbox[n]  = sbox[jv];
            sbox[jv] = held;
            kpos     = (kpos + 1 >= span) ? 0 : kpos + 1;
        end
    endtask

    task automatic crypt_byte(input req_t rq);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] ks_pos;
        res_t       r;
        pos_i = pos_i + 8'd1;
        a = sbox[pos_i];
        pos_j = pos_j + a;
        b = sbox[pos_j];
        sbox[pos_i] = b;
        sbox[pos_j] = a;
        ks_pos = a + b;
        r.result_byte = rq.data_byte ^ sbox[ks_pos];
        r.message_end = rq.last_byte;
        cipher_bytes.push_back(r);
    endtask

    task automatic apply_transaction(input req_t rq);
        case (rq.command)
            CMD_LOAD:  key_bytes[rq.key_index] = rq.data_byte;
            CMD_SCHED: run_key_schedule();
            CMD_CRYPT: crypt_byte(rq);
            default:   ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            for (int n = 0; n < PERM_DEPTH; n++)
            begin
                sbox[n] = 8'(n);
            end
            for (int n = 0; n < KEY_DEPTH; n++)
            begin
                key_bytes[n] = 8'h00;
            end
            pos_i   = 8'h00;
            pos_j   = 8'h00;
            key_len = KEY_LEN_RESET;
            cipher_bytes.delete();
            failures = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_len = cfg_data;
            end
            if (start && !busy)
            begin
                apply_transaction(request);
            end
            if (result_valid)
            begin
                if (cipher_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("result %h/%b with nothing outstanding",
                                              result.result_byte, result.message_end));
                end
                else
                begin
                    want = cipher_bytes.pop_front();
                    if (result.result_byte !== want.result_byte)
                    begin
                        report_mismatch($sformatf("result_byte %h, expected %h",
                                                  result.result_byte, want.result_byte));
                    end
                    if (result.message_end !== want.message_end)
                    begin
                        report_mismatch($sformatf("message_end %b, expected %b",
                                                  result.message_end, want.message_end));
                    end
                end
            end
        end
        pending = cipher_bytes.size();
    end

endmodule

// ----- bench/rc4_stream_cipher_tb.sv -----
`timescale 1ns / 1ps
// rc4 engine testbench top: clock, reset, command and key length stimulus, verdict
module rc4_stream_cipher_tb;
    import rc4_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         ITEM_TARGET = 1750;
    localparam int         NUM_PHASES  = 8;
    // a key schedule keeps the engine busy through all of its swaps after it is taken
    localparam int         SETTLE_CYCLES = 1040;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    req_t               request;
    logic               result_valid;
    res_t               result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [KLEN_W-1:0]  cfg_data;
    int                 failures;
    int                 pending;

    int                 items_sent;
    int                 burst_left;
    bit                 key_written [KEY_DEPTH];
    logic [KLEN_W-1:0]  key_len_now;
    logic [KLEN_W-1:0]  phase_len [NUM_PHASES];

    rc4_stream_cipher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    rc4_stream_cipher_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int key_span(input logic [KLEN_W-1:0] len);
        if (len == '0)
        begin
            return 1;
        end
        if (int'(len) > KEY_DEPTH)
        begin
            return KEY_DEPTH;
        end
        return int'(len);
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] idx,
                             input logic [7:0] data, input logic last);
        req_t rq;
        int   gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        rq.command   = cmd;
        rq.key_index = idx;
        rq.data_byte = data;
        rq.last_byte = last;
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (cmd != CMD_SPARE)
        begin
            items_sent++;
        end
    endtask

    task automatic load_key(input int pos, input logic [7:0] data);
        send_item(CMD_LOAD, 8'(pos), data, 1'($urandom));
        key_written[pos] = 1'b1;
    endtask

    // stray transactions: dropped codes and loads anywhere in the store
    task automatic maybe_noise();
        int pos;
        if ($urandom_range(0, 19) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_item(CMD_SPARE, 8'($urandom), 8'($urandom), 1'($urandom));
            end
            else
            begin
                pos = $urandom_range(0, KEY_DEPTH - 1);
                load_key(pos, 8'($urandom));
            end
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_key_length(input logic [KLEN_W-1:0] len);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        key_len_now = len;
    endtask

    task automatic crypt_message();
        int msg_len;
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                              : $urandom_range(1, 40);
        for (int n = 0; n < msg_len; n++)
        begin
            maybe_noise();
            send_item(CMD_CRYPT, 8'($urandom), 8'($urandom), n == msg_len - 1);
        end
    endtask

    // fresh key bytes, schedule, then a message; sometimes the keystream just carries on
    task automatic key_session();
        int span;
        span = key_span(key_len_now);
        if ($urandom_range(0, 7) != 0)
        begin
            for (int n = 0; n < span; n++)
            begin
                if (!key_written[n] || $urandom_range(0, 1) == 1)
                begin
                    maybe_noise();
                    load_key(n, 8'($urandom));
                end
            end
            send_item(CMD_SCHED, 8'($urandom), 8'($urandom), 1'($urandom));
        end
        crypt_message();
        if ($urandom_range(0, 9) == 0)
        begin
            drain_results();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        items_sent = 0;
        burst_left = 0;
        key_len_now = KEY_LEN_RESET;
        phase_len = '{KEY_LEN_RESET, 9'd1, 9'd0, 9'd256, 9'd511, 9'd7, 9'd300,
                      9'($urandom_range(2, 255))};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // crypt on the reset permutation, a dropped code, extreme fields
        send_item(CMD_CRYPT, 8'h00, 8'h00, 1'b0);
        send_item(CMD_CRYPT, 8'hff, 8'hff, 1'b1);
        send_item(CMD_SPARE, 8'hff, 8'hff, 1'b1);
        load_key(KEY_DEPTH - 1, 8'hff);
        for (int n = 0; n < 16; n++)
        begin
            load_key(n, (n == 0) ? 8'h00 : (n == 15) ? 8'hff : 8'($urandom));
        end
        send_item(CMD_SCHED, 8'h00, 8'h00, 1'b0);
        send_item(CMD_CRYPT, 8'h00, 8'h00, 1'b0);
        send_item(CMD_CRYPT, 8'h5a, 8'ha5, 1'b0);
        send_item(CMD_CRYPT, 8'hff, 8'hff, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                write_key_length(phase_len[p]);
            end
            while (items_sent < (p + 1) * ITEM_TARGET / NUM_PHASES)
            begin
                key_session();
            end
        end

        drain_results();
        repeat (20) @(negedge clk);
        if (failures == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/rc4_pkg.sv
design/rc4_stream_cipher.sv
design/rc4_chk.sv
bench/rc4_stream_cipher_checker.sv
bench/rc4_stream_cipher_tb.sv
